// File: sv/bpe_pkg.sv
// shared types and codes for the button press event block
package bpe_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CfgIdxW = 2;

  // default depth of the queue between classifier and state machine
  localparam int unsigned QueueDepthDefault = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdlePeriod     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebouncePeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongPeriod     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRepeatPeriod   = 2'd3;

  // register reset values
  localparam logic [PeriodW-1:0] IdlePeriodRst     = 16'd10;
  localparam logic [PeriodW-1:0] DebouncePeriodRst = 16'd20;
  localparam logic [PeriodW-1:0] LongPeriodRst     = 16'd500;
  localparam logic [PeriodW-1:0] RepeatPeriodRst   = 16'd100;

  // event codes
  localparam logic [CodeW-1:0] EvNone    = 3'd0;
  localparam logic [CodeW-1:0] EvPress   = 3'd1;
  localparam logic [CodeW-1:0] EvLong    = 3'd2;
  localparam logic [CodeW-1:0] EvRepeat  = 3'd3;
  localparam logic [CodeW-1:0] EvRelease = 3'd4;

  // mode codes as seen on the result
  localparam logic [CodeW-1:0] ModeIdleCode     = 3'd0;
  localparam logic [CodeW-1:0] ModeDebounceCode = 3'd1;
  localparam logic [CodeW-1:0] ModePressedCode  = 3'd2;
  localparam logic [CodeW-1:0] ModeRepeatCode   = 3'd3;
  localparam logic [CodeW-1:0] ModeReleasedCode = 3'd4;

  // classified sample held in the queue
  typedef struct packed {
    logic [TimeW-1:0] time_now;
    logic             low;
  } bpe_item_t;

  // queue to back end handshake
  typedef struct packed {
    logic      valid;
    bpe_item_t item;
  } bpe_queue_t;

endpackage

// File: sv/bpe_front.sv
// front end: accepts samples, classifies the pin and queues them
module bpe_front #(
  parameter int unsigned Depth = bpe_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bpe_pkg::TimeW-1:0]     time_now_i,
  input  logic                          pin_level_i,
  output bpe_pkg::bpe_queue_t           queue_o,
  input  logic                          pop_i
);
  import bpe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bpe_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  bpe_item_t       item_in;

  // active-low pin: zero means pressed
  assign item_in.time_now = time_now_i;
  assign item_in.low      = ~pin_level_i;

  assign in_ready_o = (count_q != FullCnt);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign queue_o.valid = (count_q != '0);
  assign queue_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// File: sv/bpe_back.sv
// back end: button state machine, configuration registers and result register
module bpe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpe_pkg::PeriodW-1:0]   cfg_data_i,
  input  bpe_pkg::bpe_queue_t           queue_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpe_pkg::CodeW-1:0]     event_code_o,
  output logic [bpe_pkg::CodeW-1:0]     mode_now_o
);
  import bpe_pkg::*;

  typedef enum logic [CodeW-1:0] {
    ModeIdle     = ModeIdleCode,
    ModeDebounce = ModeDebounceCode,
    ModePressed  = ModePressedCode,
    ModeRepeat   = ModeRepeatCode,
    ModeReleased = ModeReleasedCode
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [PeriodW-1:0] timeout_q, timeout_d;
  logic [TimeW-1:0]   last_time_q, last_time_d;
  logic [CodeW-1:0]   event_q, event_d;
  logic               out_valid_q, out_valid_d;

  logic [PeriodW-1:0] idle_period_q, debounce_period_q, long_period_q, repeat_period_q;

  logic [TimeW-1:0]   elapsed;
  logic [PeriodW-1:0] limit;
  logic               expired;
  logic               low;
  logic [TimeW-1:0]   now;

  // take a sample whenever the result slot is free or being emptied
  assign pop_o = queue_i.valid && (!out_valid_q || out_ready_i);

  assign now     = queue_i.item.time_now;
  assign low     = queue_i.item.low;
  assign elapsed = now - last_time_q;
  // idle compares against the live register, other modes against the latched limit
  assign limit   = (mode_q == ModeIdle) ? idle_period_q : timeout_q;
  assign expired = elapsed > {{(TimeW-PeriodW){1'b0}}, limit};

  always_comb begin
    mode_d      = mode_q;
    timeout_d   = timeout_q;
    last_time_d = last_time_q;
    event_d     = EvNone;
    unique case (mode_q)
      ModeIdle: begin
        if (expired) begin
          if (low) begin
            mode_d    = ModeDebounce;
            timeout_d = debounce_period_q;
          end else begin
            timeout_d = idle_period_q;
          end
          last_time_d = now;
        end
      end
      ModeDebounce: begin
        if (low) begin
          if (expired) begin
            event_d     = EvPress;
            mode_d      = ModePressed;
            timeout_d   = long_period_q;
            last_time_d = now;
          end
        end else begin
          mode_d    = ModeIdle;
          timeout_d = idle_period_q;
        end
      end
      ModePressed: begin
        if (low) begin
          if (expired) begin
            event_d     = EvLong;
            mode_d      = ModeRepeat;
            timeout_d   = repeat_period_q;
            last_time_d = now;
          end
        end else begin
          mode_d    = ModeReleased;
          timeout_d = idle_period_q;
        end
      end
      ModeRepeat: begin
        if (low) begin
          if (expired) begin
            event_d     = EvRepeat;
            last_time_d = now;
          end
        end else begin
          mode_d    = ModeReleased;
          timeout_d = idle_period_q;
        end
      end
      ModeReleased: begin
        event_d     = EvRelease;
        last_time_d = now;
        mode_d      = ModeIdle;
        timeout_d   = idle_period_q;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      timeout_q   <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
      event_q     <= EvNone;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        mode_q      <= mode_d;
        timeout_q   <= timeout_d;
        last_time_q <= last_time_d;
        event_q     <= event_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_period_q     <= IdlePeriodRst;
      debounce_period_q <= DebouncePeriodRst;
      long_period_q     <= LongPeriodRst;
      repeat_period_q   <= RepeatPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdlePeriod:     idle_period_q     <= cfg_data_i;
        CfgDebouncePeriod: debounce_period_q <= cfg_data_i;
        CfgLongPeriod:     long_period_q     <= cfg_data_i;
        CfgRepeatPeriod:   repeat_period_q   <= cfg_data_i;
        default:           idle_period_q     <= idle_period_q;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;
  assign mode_now_o   = mode_q;

endmodule

// File: sv/button_press_event_fsm.sv
// top level of the button press event block: queue front end and state machine back end
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------
//  in       | input     | in_valid_i / in_ready_o       | time_now_i, pin_level_i
//  out      | output    | out_valid_o / out_ready_i     | event_code_o, mode_now_o
//  cfg      | input     | cfg_we_i (no wait)            | cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while out_ready_i stays high; every input transaction gives exactly one result
// a transaction is registered in the queue, then its result is registered by the state update
// the state update (one 32-bit subtract and compare) is the loop that sets the rate
// reset empties the queue, returns the mode to idle, zeroes the latched limit and the
// last time, clears the result, and loads the default periods into the registers
// a stalled output holds its result while the queue keeps taking input until it is full
module button_press_event_fsm #(
  parameter int unsigned QueueDepth = bpe_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bpe_pkg::TimeW-1:0]     time_now_i,
  input  logic                          pin_level_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpe_pkg::CodeW-1:0]     event_code_o,
  output logic [bpe_pkg::CodeW-1:0]     mode_now_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [bpe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpe_pkg::PeriodW-1:0]   cfg_data_i
);
  import bpe_pkg::*;

  bpe_queue_t queue;
  logic       pop;

  // front end: classify the pin level and buffer the transaction
  bpe_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .time_now_i  (time_now_i),
    .pin_level_i (pin_level_i),
    .queue_o     (queue),
    .pop_i       (pop)
  );

  // back end: timeouts, mode changes and the result register
  bpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .queue_i      (queue),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .mode_now_o   (mode_now_o)
  );

  // a press event always lands in the pressed mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == EvPress) |-> (mode_now_o == ModePressedCode))
    else $error("press event without pressed mode");

  // a long press event always moves into the repeat mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == EvLong) |-> (mode_now_o == ModeRepeatCode))
    else $error("long press event without repeat mode");

  // a release event always returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == EvRelease) |-> (mode_now_o == ModeIdleCode))
    else $error("release event without idle mode");

  // the back end only takes from the queue when it holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> queue.valid)
    else $error("pop from empty queue");

endmodule
